// File: rtl/core/gpd_pkg.sv
package gpd_pkg;

    localparam int FRAME_BYTES     = 8;
    localparam int BYTE_W          = 8;
    localparam int FRAME_W         = FRAME_BYTES * BYTE_W;
    localparam int NUM_BUTTONS     = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h80;
    localparam logic [6:0]        CHECK_MASK     = 7'h7f;
    localparam logic [BYTE_W-1:0] STICK_BIAS     = 8'h40;

    typedef logic [BYTE_W-1:0] t_byte;

    // classified word handed from front to back
    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] frame;
    } t_frame_word;

endpackage

// File: rtl/core/gamepad_packet_decoder.sv
// Gamepad packet decoder. Each input word is a snapshot of an 8-byte circular
// receive buffer; it is rotated to the last start byte, checked against the
// 7-bit checksum in byte 7, and a good frame updates the stored sticks and the
// 16 button edge trackers. Every input word yields exactly one output word,
// with frame_ok telling whether this snapshot was good; a bad one repeats the
// stored values. One word per cycle sustained while the output side is not
// stalled; a word is held in the queue, then in the output register. The front
// (search, rotate, checksum) feeds the back (state update, output register)
// through a QUEUE_DEPTH-entry queue; input stall rises only when it is full.
// start_byte may be written only while no word is in flight.
module gamepad_packet_decoder
    import gpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [BYTE_W-1:0]        i_cfg_wr_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [FRAME_W-1:0]       i_frame_bytes,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_frame_ok,
    output logic signed [7:0]        o_left_x,
    output logic signed [7:0]        o_left_y,
    output logic signed [7:0]        o_right_x,
    output logic signed [7:0]        o_right_y,
    output logic [2*NUM_BUTTONS-1:0] o_button_states
);

    t_frame_word front_word;
    t_frame_word back_word;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;

    assign o_in_stall = q_full;

    gpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_frame_bytes (i_frame_bytes),
        .o_word        (front_word)
    );

    gpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_in_valid),
        .i_push_word (front_word),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_word  (back_word),
        .o_empty     (q_empty)
    );

    gpd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_word          (back_word),
        .i_word_avail    (!q_empty),
        .o_pop           (q_pop),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_frame_ok      (o_frame_ok),
        .o_left_x        (o_left_x),
        .o_left_y        (o_left_y),
        .o_right_x       (o_right_x),
        .o_right_y       (o_right_y),
        .o_button_states (o_button_states)
    );

endmodule

// File: rtl/core/gpd_front.sv
module gpd_front
    import gpd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [BYTE_W-1:0]  i_cfg_wr_data,
    input  logic [FRAME_W-1:0] i_frame_bytes,
    output t_frame_word        o_word
);

    localparam int POS_W = $clog2(FRAME_BYTES);

    t_byte             r_start_byte;
    t_byte             raw [FRAME_BYTES];
    t_byte             fr  [FRAME_BYTES];
    logic              found;
    logic [POS_W-1:0]  pos;
    logic [6:0]        sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
        end else if (i_cfg_wr_en) begin
            r_start_byte <= i_cfg_wr_data;
        end
    end

    always_comb begin
        found = 1'b0;
        pos   = '0;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            raw[i] = i_frame_bytes[i*BYTE_W +: BYTE_W];
            if (raw[i] == r_start_byte) begin
                found = 1'b1;
                pos   = POS_W'(i);
            end
        end
    end

    // rotate so the last start byte leads
    always_comb begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
            fr[i] = found ? raw[POS_W'(pos + POS_W'(i))] : '0;
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 1; i < FRAME_BYTES - 1; i++) begin
            sum = sum + fr[i][6:0];
        end
    end

    always_comb begin
        o_word.ok = (fr[0] == r_start_byte) &&
                    ({1'b0, sum & CHECK_MASK} == fr[FRAME_BYTES-1]);
        for (int i = 0; i < FRAME_BYTES; i++) begin
            o_word.frame[i*BYTE_W +: BYTE_W] = fr[i];
        end
    end

endmodule

// File: rtl/core/gpd_queue.sv
module gpd_queue
    import gpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_frame_word i_push_word,
    output logic        o_full,
    input  logic        i_pop,
    output t_frame_word o_pop_word,
    output logic        o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame_word       r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_word = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

// File: rtl/core/gpd_back.sv
module gpd_back
    import gpd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_frame_word             i_word,
    input  logic                    i_word_avail,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_frame_ok,
    output logic signed [7:0]       o_left_x,
    output logic signed [7:0]       o_left_y,
    output logic signed [7:0]       o_right_x,
    output logic signed [7:0]       o_right_y,
    output logic [2*NUM_BUTTONS-1:0] o_button_states
);

    typedef enum logic [1:0] {
        BTN_RELEASE      = 2'd0,
        BTN_PUSH_EDGE    = 2'd1,
        BTN_PUSH         = 2'd2,
        BTN_RELEASE_EDGE = 2'd3
    } t_btn;

    logic               r_valid;
    logic               r_ok;
    logic [FRAME_W-1:0] r_last_frame;
    t_btn               r_trk [NUM_BUTTONS];
    t_btn               n_trk [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] btn_word;

    assign o_pop   = i_word_avail && (!r_valid || !i_stall);
    assign btn_word = {i_word.frame[1*BYTE_W +: BYTE_W], i_word.frame[2*BYTE_W +: BYTE_W]};

    always_comb begin
        for (int k = 0; k < NUM_BUTTONS; k++) begin
            unique case (r_trk[k])
                BTN_PUSH_EDGE, BTN_PUSH:
                    n_trk[k] = btn_word[k] ? BTN_PUSH : BTN_RELEASE_EDGE;
                BTN_RELEASE, BTN_RELEASE_EDGE:
                    n_trk[k] = btn_word[k] ? BTN_PUSH_EDGE : BTN_RELEASE;
                default:
                    n_trk[k] = BTN_RELEASE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_ok         <= 1'b0;
            r_last_frame <= '0;
            for (int k = 0; k < NUM_BUTTONS; k++) begin
                r_trk[k] <= BTN_RELEASE;
            end
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_ok    <= i_word.ok;
                if (i_word.ok) begin
                    r_last_frame <= i_word.frame;
                    r_trk        <= n_trk;
                end
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_frame_ok = r_ok;
    assign o_left_x   = r_last_frame[3*BYTE_W +: BYTE_W] - STICK_BIAS;
    assign o_left_y   = r_last_frame[4*BYTE_W +: BYTE_W] - STICK_BIAS;
    assign o_right_x  = r_last_frame[5*BYTE_W +: BYTE_W] - STICK_BIAS;
    assign o_right_y  = r_last_frame[6*BYTE_W +: BYTE_W] - STICK_BIAS;

    always_comb begin
        for (int k = 0; k < NUM_BUTTONS; k++) begin
            o_button_states[2*k +: 2] = r_trk[k];
        end
    end

endmodule
